>>> sv/utf8_code_point_decoder_macros.svh
// Assertion macros for the UTF-8 code point decoder.
// Each macro expects a clock named clk and a reset named rst in the module that uses it.
`ifndef UTF8_CODE_POINT_DECODER_MACROS_SVH
`define UTF8_CODE_POINT_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8DEC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8dec: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define U8DEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8dec: next-cycle check failed");

`endif

>>> sv/u8dec_pkg.sv
// Shared types and constants for the UTF-8 code point decoder.
// Has no dependencies; used by u8dec_step and utf8_code_point_decoder.
package u8dec_pkg;

  localparam int PointWidth = 21;

  typedef enum logic [1:0] {
    ST_ABSORBED  = 2'd0,
    ST_COMPLETE  = 2'd1,
    ST_INVALID   = 2'd2,
    ST_NEED_MORE = 2'd3
  } status_t;

  localparam logic REQ_DECODE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] CONT_BITS  = 8'h3F;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;
  localparam logic [7:0] LEAD4_BITS = 8'h07;

  typedef struct packed {
    logic [1:0]            bytes_left;
    logic [PointWidth-1:0] partial_point;
  } dec_state_t;

  typedef struct packed {
    status_t               status;
    logic [PointWidth-1:0] code_point;
    logic                  stopped;
  } result_t;

endpackage

>>> sv/utf8_code_point_decoder.sv
// UTF-8 decoder: takes one byte per request and gives one result per request, a code point
// once a character completes. It accepts one request per clock unless out_ready stalls the
// output, as the continuation count and partial code point are updated per request; each
// request passes through the input register, then the result register. While a result
// waits, the input register takes one more request and then holds the input side off.
// Setting stop_at_nul marks the completion of U+0000 as a stop. There is no clearing pass
// after reset. Depends on u8dec_pkg, u8dec_step.
`include "utf8_code_point_decoder_macros.svh"

module utf8_code_point_decoder
  import u8dec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_chunk,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic [PointWidth-1:0] code_point,
  output logic                  stopped
);

  logic       stop_at_nul;
  logic       s1_valid;
  logic       s1_req;
  logic [7:0] s1_byte;
  logic       s1_eoc;
  logic       advance;
  dec_state_t dec_state;
  dec_state_t dec_state_next;
  result_t    result;
  result_t    result_next;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_at_nul <= 1'b0;
    end else if (cfg_valid) begin
      stop_at_nul <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req  <= req_type;
      s1_byte <= data_byte;
      s1_eoc  <= end_of_chunk;
    end
  end

  u8dec_step u_step (
    .req_type     (s1_req),
    .data_byte    (s1_byte),
    .end_of_chunk (s1_eoc),
    .stop_at_nul  (stop_at_nul),
    .cur          (dec_state),
    .nxt          (dec_state_next),
    .res          (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_state <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        dec_state <= dec_state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      result <= result_next;
    end
  end

  assign status     = result.status;
  assign code_point = result.code_point;
  assign stopped    = result.stopped;

  `U8DEC_ASSERT_NOW(a_stop_only_on_nul, out_valid && stopped,
                    status == ST_COMPLETE && code_point == '0)
  `U8DEC_ASSERT_NOW(a_point_only_on_complete, out_valid && status != ST_COMPLETE,
                    code_point == '0 && !stopped)
  `U8DEC_ASSERT_NEXT(a_clear_empties, advance && s1_valid && s1_req == REQ_CLEAR,
                     dec_state == '0)
  `U8DEC_ASSERT_NOW(a_idle_state_empty, dec_state.bytes_left == 2'd0,
                    dec_state.partial_point == '0)

endmodule

>>> sv/u8dec_step.sv
// Decode logic for one request: next decoder state and the result.
// Depends on u8dec_pkg.
module u8dec_step
  import u8dec_pkg::*;
(
  input  logic       req_type,
  input  logic [7:0] data_byte,
  input  logic       end_of_chunk,
  input  logic       stop_at_nul,
  input  dec_state_t cur,
  output dec_state_t nxt,
  output result_t    res
);

  logic [PointWidth-1:0] shifted;
  logic [1:0]            left_after;
  status_t               absorbed;

  assign shifted    = {cur.partial_point[PointWidth-7:0], data_byte[5:0]};
  assign left_after = cur.bytes_left - 2'd1;
  assign absorbed   = end_of_chunk ? ST_NEED_MORE : ST_ABSORBED;

  always_comb begin
    nxt = cur;
    res = '{status: ST_ABSORBED, code_point: '0, stopped: 1'b0};
    if (req_type == REQ_CLEAR) begin
      nxt = '0;
    end else if (cur.bytes_left != 2'd0) begin
      if ((data_byte & CONT_MASK) != CONT_TAG) begin
        res.status = ST_INVALID;
      end else if (left_after == 2'd0) begin
        nxt = '0;
        res.status     = ST_COMPLETE;
        res.code_point = shifted;
        res.stopped    = stop_at_nul && (shifted == '0);
      end else begin
        nxt.bytes_left    = left_after;
        nxt.partial_point = shifted;
        res.status        = absorbed;
      end
    end else if (data_byte[7] == 1'b0) begin
      nxt = '0;
      res.status     = ST_COMPLETE;
      res.code_point = PointWidth'(data_byte);
      res.stopped    = stop_at_nul && (data_byte == 8'd0);
    end else if ((data_byte & LEAD2_MASK) == LEAD2_TAG) begin
      nxt.bytes_left    = 2'd1;
      nxt.partial_point = PointWidth'(data_byte & LEAD2_BITS);
      res.status        = absorbed;
    end else if ((data_byte & LEAD3_MASK) == LEAD3_TAG) begin
      nxt.bytes_left    = 2'd2;
      nxt.partial_point = PointWidth'(data_byte & LEAD3_BITS);
      res.status        = absorbed;
    end else if ((data_byte & LEAD4_MASK) == LEAD4_TAG) begin
      nxt.bytes_left    = 2'd3;
      nxt.partial_point = PointWidth'(data_byte & LEAD4_BITS);
      res.status        = absorbed;
    end else begin
      res.status = ST_INVALID;
    end
  end

endmodule
